@@ rtl/ucpi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ucpi_pkg;

    // Register indexes on the configuration port
    localparam logic CFG_LOWER = 1'b0;
    localparam logic CFG_UPPER = 1'b1;

    // Pipeline geometry: input stage, square stage, one stage per quotient bit
    localparam int FRONT_STAGES = 2;
    localparam int DIV_STEPS    = 32;
    localparam int CDF_STEPS    = 16;
    localparam int STAGES       = FRONT_STAGES + DIV_STEPS;

    localparam int IN_W      = 32;
    localparam int CDF_W     = 17;
    localparam int INTEG_W   = 34;
    localparam int TDATA_W   = 88;
    localparam int PAD_W     = TDATA_W - CDF_W - 2 * INTEG_W;

    localparam logic [CDF_W-1:0] CDF_ONE = 17'h10000;

    // One pipeline slot. num_* hold the remaining numerator bits and collect
    // quotient bits from the bottom; after the last step they hold the quotient.
    typedef struct packed {
        logic        err;
        logic        lo_side;
        logic        hi_side;
        logic [31:0] d;
        logic [33:0] edge_val;
        logic [32:0] rem_b;
        logic [31:0] num_b;
        logic [32:0] rem_a;
        logic [31:0] num_a;
        logic [31:0] rem_c;
        logic [15:0] num_c;
    } ucpi_pipe_t;

    // Classify T against the bounds and form the differences.
    function automatic ucpi_pipe_t ucpi_front(logic [31:0] t, logic [31:0] l,
                                              logic [31:0] u);
        ucpi_pipe_t r;
        r          = '0;
        r.err      = $signed(u) <= $signed(l);
        r.lo_side  = $signed(t) <= $signed(l);
        r.hi_side  = $signed(t) >= $signed(u);
        r.d        = u - l;
        r.num_b    = t - l;
        r.num_a    = u - t;
        r.edge_val = {2'b00, (r.lo_side ? (l - t) : (t - u))};
        return r;
    endfunction

    // Square both distances, seed the three dividers, form the edge integral.
    function automatic ucpi_pipe_t ucpi_square(ucpi_pipe_t p);
        ucpi_pipe_t  r;
        logic [63:0] xx;
        logic [63:0] yy;
        r          = p;
        xx         = 64'(p.num_b) * 64'(p.num_b);
        yy         = 64'(p.num_a) * 64'(p.num_a);
        r.rem_b    = {1'b0, xx[63:32]};
        r.num_b    = xx[31:0];
        r.rem_a    = {1'b0, yy[63:32]};
        r.num_a    = yy[31:0];
        r.rem_c    = p.num_b;
        r.num_c    = '0;
        r.edge_val = {3'b000, p.d[31:1]} + p.edge_val;
        return r;
    endfunction

    // One restoring step: divisor 2D for the integrals, D for the CDF.
    function automatic ucpi_pipe_t ucpi_div_step(ucpi_pipe_t p, logic cdf_en);
        ucpi_pipe_t  r;
        logic [33:0] dv;
        logic [33:0] cat_b;
        logic [33:0] cat_a;
        logic [32:0] cat_c;
        r     = p;
        dv    = {1'b0, p.d, 1'b0};
        cat_b = {p.rem_b, p.num_b[31]};
        cat_a = {p.rem_a, p.num_a[31]};
        cat_c = {p.rem_c, p.num_c[15]};
        if (cat_b >= dv)
        begin
            r.rem_b = 33'(cat_b - dv);
            r.num_b = {p.num_b[30:0], 1'b1};
        end
        else
        begin
            r.rem_b = cat_b[32:0];
            r.num_b = {p.num_b[30:0], 1'b0};
        end
        if (cat_a >= dv)
        begin
            r.rem_a = 33'(cat_a - dv);
            r.num_a = {p.num_a[30:0], 1'b1};
        end
        else
        begin
            r.rem_a = cat_a[32:0];
            r.num_a = {p.num_a[30:0], 1'b0};
        end
        if (cdf_en)
        begin
            if (cat_c >= {1'b0, p.d})
            begin
                r.rem_c = 32'(cat_c - {1'b0, p.d});
                r.num_c = {p.num_c[14:0], 1'b1};
            end
            else
            begin
                r.rem_c = cat_c[31:0];
                r.num_c = {p.num_c[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/uniform_cdf_partial_integrals.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Uniform distribution on [lower, upper]: CDF and the two partial integrals.
//
// Input stream (s_axis_*): one signed Q16.16 query time per transfer.
// Output stream (m_axis_*): one result per query, in order: the CDF (Q1.16,
// 65536 is one), the integral of the CDF up to T and the integral of the
// survival function from T on (both unsigned Q18.16), and a bounds error flag
// in tuser that is set, with all data zero, when upper <= lower.
// Configuration: cfg_we writes cfg_data into lower (index 0) or upper
// (index 1); write only while no query is in flight.
//
// Throughput is one query per cycle while m_axis_tready is high. Each query
// passes through 35 registers on its way to m_axis, the first of which
// loads at the transfer edge: one input stage, one squaring stage,
// 32 restoring-division stages (one quotient bit each, the CDF quotient
// taking the first 16 of them) and the output register.
// Reset clears all valid bits and loads lower = 0, upper = 1.0.
// When the receiver stalls, the output holds and the pipeline closes up
// its bubbles; s_axis_tready drops only once every stage is full.
module uniform_cdf_partial_integrals
    import ucpi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [IN_W-1:0]    s_axis_tdata,   // [31:0] query_time
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // [16:0] cdf_value, [50:17]
                                                    // integral_below, [84:51]
                                                    // integral_above, rest zero
    output logic                    m_axis_tuser,   // [0] bounds_error
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [31:0]        cfg_data
);

    logic [31:0]        lower_reg;
    logic [31:0]        upper_reg;

    // Stage valids and payload
    logic [STAGES-1:0]  v_reg;
    ucpi_pipe_t         st_reg  [STAGES];
    ucpi_pipe_t         st_next [STAGES];
    logic [STAGES-1:0]  v_in;

    // Stage i may load when it or any stage after it has a hole,
    // or the output is draining this cycle.
    logic [STAGES:0]    all_valid;
    logic [STAGES:0]    load;

    logic               out_valid_reg;
    logic [CDF_W-1:0]   out_cdf_reg;
    logic [INTEG_W-1:0] out_below_reg;
    logic [INTEG_W-1:0] out_above_reg;
    logic               out_err_reg;

    logic [CDF_W-1:0]   out_cdf_next;
    logic [INTEG_W-1:0] out_below_next;
    logic [INTEG_W-1:0] out_above_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= 32'h0000_0000;
            upper_reg <= 32'h0001_0000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOWER: lower_reg <= cfg_data;
                CFG_UPPER: upper_reg <= cfg_data;
                default:   lower_reg <= lower_reg;
            endcase
        end
    end

    assign all_valid = {out_valid_reg, v_reg};

    genvar i;
    generate
        for (i = 0; i <= STAGES; i++)
        begin : g_load
            assign load[i] = m_axis_tready | ~(&all_valid[STAGES:i]);
        end

        for (i = 0; i < STAGES; i++)
        begin : g_stage
            if (i == 0)
            begin : g_front
                assign v_in[i]    = s_axis_tvalid;
                assign st_next[i] = ucpi_front(s_axis_tdata, lower_reg, upper_reg);
            end
            else if (i == 1)
            begin : g_square
                assign v_in[i]    = v_reg[i-1];
                assign st_next[i] = ucpi_square(st_reg[i-1]);
            end
            else
            begin : g_div
                assign v_in[i]    = v_reg[i-1];
                assign st_next[i] = ucpi_div_step(st_reg[i-1],
                                        (i - FRONT_STAGES) < CDF_STEPS);
            end

            // Advance the valid bit; a bubble moves on like an item
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[i] <= 1'b0;
                end
                else if (load[i])
                begin
                    v_reg[i] <= v_in[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (load[i] && v_in[i])
                begin
                    st_reg[i] <= st_next[i];
                end
            end
        end
    endgenerate

    // Pick the piece that applies: error, at or below lower, at or above upper, or between
    always_comb
    begin
        if (st_reg[STAGES-1].err || st_reg[STAGES-1].lo_side)
        begin
            out_cdf_next   = '0;
            out_below_next = '0;
        end
        else if (st_reg[STAGES-1].hi_side)
        begin
            out_cdf_next   = CDF_ONE;
            out_below_next = st_reg[STAGES-1].edge_val;
        end
        else
        begin
            out_cdf_next   = {1'b0, st_reg[STAGES-1].num_c};
            out_below_next = {2'b00, st_reg[STAGES-1].num_b};
        end

        if (st_reg[STAGES-1].err || st_reg[STAGES-1].hi_side)
        begin
            out_above_next = '0;
        end
        else if (st_reg[STAGES-1].lo_side)
        begin
            out_above_next = st_reg[STAGES-1].edge_val;
        end
        else
        begin
            out_above_next = {2'b00, st_reg[STAGES-1].num_a};
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load[STAGES])
        begin
            out_valid_reg <= v_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[STAGES] && v_reg[STAGES-1])
        begin
            out_cdf_reg   <= out_cdf_next;
            out_below_reg <= out_below_next;
            out_above_reg <= out_above_next;
            out_err_reg   <= st_reg[STAGES-1].err;
        end
    end

    assign s_axis_tready = load[0];
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_above_reg, out_below_reg, out_cdf_reg};
    assign m_axis_tuser  = out_err_reg;

endmodule

`default_nettype wire

@@ rtl/ucpi_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ucpi_checker
    import ucpi_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    input  wire logic [TDATA_W-1:0] m_axis_tdata,
    input  wire logic               m_axis_tuser
);

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Bad bounds give all-zero results
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("nonzero data with bounds error");

    // CDF never exceeds one
    a_cdf_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[CDF_W-1:0] <= CDF_ONE)
        else $error("cdf above one");

    // At or past the upper bound nothing survives
    a_full_cdf: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser && m_axis_tdata[CDF_W-1:0] == CDF_ONE
            |-> m_axis_tdata[CDF_W+2*INTEG_W-1:CDF_W+INTEG_W] == '0)
        else $error("survival integral nonzero at full cdf");

endmodule

bind uniform_cdf_partial_integrals ucpi_checker u_ucpi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
